[rtl/npa_pkg.sv]
// ----------------------------------------------------------------------------
// npa_pkg
// Types and constants shared by the number pool allocator.
// ----------------------------------------------------------------------------
package npa_pkg;

  localparam int unsigned PoolSize = 256;
  localparam int unsigned IdW      = 8;
  localparam int unsigned CntW     = 9;

  localparam logic [CntW-1:0] POOL_SIZE = CntW'(PoolSize);
  localparam logic [CntW-1:0] CAP_RESET = CntW'(256);

  // action codes
  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_CHECK   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  typedef struct packed {
    logic [1:0]     action;
    logic [IdW-1:0] number;
  } npa_req_t;

  typedef struct packed {
    logic           ok;
    logic [IdW-1:0] granted_number;
  } npa_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } npa_state_e;

endpackage

[rtl/npa_ram.sv]
// ----------------------------------------------------------------------------
// npa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module npa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/number_pool_allocator_unit.sv]
// ----------------------------------------------------------------------------
// number_pool_allocator_unit
// Identifier allocator: free stack plus fresh counter, in-use bitmap in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_i and raise start; the transaction is taken at
//   a rising edge where start is high and busy is low. Actions: allocate,
//   check availability, release.
//   Result channel: rsp_o is shown for one cycle with rsp_valid_o high; it is
//   registered at the end of the execute state that follows the command edge.
//   The receiver cannot stall; the next command may be taken in the cycle the
//   previous result is shown.
//   Flow: no new command is taken while one executes (busy high). The
//   command edge registers the free stack top and bitmap entry reads; the
//   execute state resolves the action and writes both RAMs back.
//   Configuration: cfg_data_i sets the pool capacity (saturates at 256);
//   cfg_ready_o is always high. Write it only while the block is idle.
//   Reset: counters clear at once, then a clearing pass zeroes all 256
//   entries of the in-use bitmap, one entry a cycle, with busy held high.
//   Configuration writes are taken during the pass.
// ----------------------------------------------------------------------------
module number_pool_allocator_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  npa_pkg::npa_req_t req_i,
  output logic              rsp_valid_o,
  output npa_pkg::npa_rsp_t rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [8:0]        cfg_data_i
);

  import npa_pkg::*;

  npa_state_e        state_q, state_d;
  logic [IdW-1:0]    clr_q, clr_d;
  logic [CntW-1:0]   cap_q;
  logic [CntW-1:0]   fresh_q, fresh_d;
  logic [CntW-1:0]   free_cnt_q, free_cnt_d;
  npa_req_t          req_q;
  npa_rsp_t          rsp_q, rsp_d;
  logic              rsp_valid_q, rsp_valid_d;

  logic              map_we;
  logic [IdW-1:0]    map_waddr;
  logic              map_wdata;
  logic              map_rdata;
  logic              stk_we;
  logic [IdW-1:0]    stk_waddr;
  logic [IdW-1:0]    stk_raddr;
  logic [IdW-1:0]    stk_rdata;
  logic [CntW-1:0]   cap_eff;
  logic              in_range;
  logic              accept;

  assign accept      = start && (state_q == ST_IDLE);
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign cap_eff     = (cap_q > POOL_SIZE) ? POOL_SIZE : cap_q;
  assign in_range    = ({1'b0, req_q.number} < cap_eff);
  assign stk_raddr   = free_cnt_q[IdW-1:0] - IdW'(1);

  npa_ram #(
    .WIDTH (1),
    .DEPTH (PoolSize)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (req_i.number),
    .rdata_o (map_rdata)
  );

  npa_ram #(
    .WIDTH (IdW),
    .DEPTH (PoolSize)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (req_q.number),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    fresh_d     = fresh_q;
    free_cnt_d  = free_cnt_q;
    rsp_d       = '0;
    rsp_valid_d = 1'b0;
    map_we      = 1'b0;
    map_waddr   = clr_q;
    map_wdata   = 1'b0;
    stk_we      = 1'b0;
    stk_waddr   = free_cnt_q[IdW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        map_we = 1'b1;
        clr_d  = clr_q + IdW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d     = ST_IDLE;
        rsp_valid_d = 1'b1;
        case (req_q.action)
          ACT_ALLOC: begin
            if (free_cnt_q != '0) begin
              // pop most recently released id
              map_we               = 1'b1;
              map_waddr            = stk_rdata;
              map_wdata            = 1'b1;
              free_cnt_d           = free_cnt_q - CntW'(1);
              rsp_d.ok             = 1'b1;
              rsp_d.granted_number = stk_rdata;
            end else if (fresh_q < cap_eff) begin
              map_we               = 1'b1;
              map_waddr            = fresh_q[IdW-1:0];
              map_wdata            = 1'b1;
              fresh_d              = fresh_q + CntW'(1);
              rsp_d.ok             = 1'b1;
              rsp_d.granted_number = fresh_q[IdW-1:0];
            end
          end
          ACT_CHECK: begin
            rsp_d.ok = in_range && !map_rdata;
          end
          ACT_RELEASE: begin
            if (in_range && map_rdata) begin
              map_we    = 1'b1;
              map_waddr = req_q.number;
              map_wdata = 1'b0;
              rsp_d.ok  = 1'b1;
              if (free_cnt_q < POOL_SIZE) begin
                stk_we     = 1'b1;
                free_cnt_d = free_cnt_q + CntW'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cap_q       <= CAP_RESET;
      fresh_q     <= '0;
      free_cnt_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fresh_q     <= fresh_d;
      free_cnt_q  <= free_cnt_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Assertions

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> rsp_valid_o)
    else $error("no result after execute cycle");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(state_q == ST_EXEC))
    else $error("result strobe without execute cycle");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.ok) |-> (rsp_o.granted_number == '0))
    else $error("refused result carries a number");

  a_free_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= POOL_SIZE)
    else $error("free stack count beyond pool size");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= POOL_SIZE)
    else $error("fresh counter beyond pool size");

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for number_pool_allocator_unit. Commands go in on the
// start/busy channel, and a small scoreboard keeps its own pool state: the
// fresh counter, the free stack, the in-use map and the capacity. For each
// command it predicts the response, and it compares each response strobe
// with the oldest prediction. A directed opening covers exhaustion, LIFO
// reuse, out-of-range checks and releases, the reserved action and
// capacity saturation. Random phases with capacities between 0 and 511
// follow, each with a set share of allocations and, when enabled, random gaps.
// ----------------------------------------------------------------------------
module testbench;
  import npa_pkg::*;

  localparam logic [1:0]  ActReserved  = 2'd3;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned NumPhases    = 8;

  class id_pool_scoreboard;
    logic [8:0]  capacity;
    int unsigned fresh_next;
    int unsigned stack_depth;
    logic [7:0]  free_ids [PoolSize];
    bit          used_map [PoolSize];
    npa_rsp_t    pending_rsp [$];
    int unsigned errors, commands, grants, refusals, releases, cap_writes;

    function new();
      capacity    = CAP_RESET;
      fresh_next  = 0;
      stack_depth = 0;
      errors      = 0;
      commands    = 0;
      grants      = 0;
      refusals    = 0;
      releases    = 0;
      cap_writes  = 0;
      foreach (used_map[i]) begin
        used_map[i] = 1'b0;
        free_ids[i] = '0;
      end
    endfunction

    function void set_capacity(logic [8:0] value);
      capacity = value;
      cap_writes++;
    endfunction

    // Predict the response of an accepted command and update the pool state.
    function void note_command(npa_req_t cmd);
      int unsigned lim;
      npa_rsp_t    rsp;
      lim = (capacity < PoolSize) ? capacity : PoolSize;
      rsp = '0;
      commands++;
      case (cmd.action)
        ACT_ALLOC: begin
          if (stack_depth > 0) begin
            // last released id first, even if now beyond the capacity
            stack_depth--;
            rsp.granted_number = free_ids[stack_depth];
            used_map[rsp.granted_number] = 1'b1;
            rsp.ok = 1'b1;
          end else if (fresh_next < lim) begin
            rsp.granted_number = 8'(fresh_next);
            used_map[fresh_next] = 1'b1;
            fresh_next++;
            rsp.ok = 1'b1;
          end
          if (rsp.ok) grants++;
          else refusals++;
        end
        ACT_CHECK: begin
          rsp.ok = (cmd.number < lim) && !used_map[cmd.number];
        end
        ACT_RELEASE: begin
          if (cmd.number < lim && used_map[cmd.number]) begin
            used_map[cmd.number] = 1'b0;
            if (stack_depth < PoolSize) begin
              free_ids[stack_depth] = cmd.number;
              stack_depth++;
            end
            rsp.ok = 1'b1;
            releases++;
          end
        end
        default: ;
      endcase
      pending_rsp.push_back(rsp);
    endfunction

    function void check_response(npa_rsp_t got);
      npa_rsp_t want;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: response with none pending: ok=%0b id=%0d", $time, got.ok,
                 got.granted_number);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.ok !== want.ok) begin
        errors++;
        $display("%0t: ok mismatch: expected %0b, actual %0b", $time, want.ok, got.ok);
      end
      if (got.granted_number !== want.granted_number) begin
        errors++;
        $display("%0t: granted_number mismatch: expected %0d, actual %0d", $time,
                 want.granted_number, got.granted_number);
      end
    endfunction

    // Random id that is currently held, for meaningful releases and checks.
    function bit pick_used(output logic [7:0] id);
      logic [7:0] held [$];
      id = '0;
      for (int i = 0; i < PoolSize; i++) begin
        if (used_map[i]) held.push_back(8'(i));
      end
      if (held.size() == 0) return 1'b0;
      id = held[$urandom_range(0, held.size() - 1)];
      return 1'b1;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  npa_req_t    req;
  logic        rsp_valid;
  npa_rsp_t    rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;
  int unsigned cycle_count = 0;

  id_pool_scoreboard pool_sb = new();

  number_pool_allocator_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Responses are checked before a same-edge command is noted: the response
  // always belongs to an earlier transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_valid) pool_sb.check_response(rsp);
      if (start && !busy) pool_sb.note_command(req);
      if (cfg_valid && cfg_ready) pool_sb.set_capacity(cfg_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timed out with %0d responses outstanding", $time,
               pool_sb.pending_rsp.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic npa_req_t make_cmd(logic [1:0] action, logic [7:0] number);
    npa_req_t c;
    c.action = action;
    c.number = number;
    return c;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap(bit idle_on);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic npa_req_t random_command(int unsigned alloc_pct);
    int unsigned r, rel_end, chk_end;
    logic [7:0]  id;
    npa_req_t    c;
    r       = $urandom_range(0, 99);
    rel_end = alloc_pct + (100 - alloc_pct) * 60 / 100;
    chk_end = alloc_pct + (100 - alloc_pct) * 92 / 100;
    c.number = 8'($urandom_range(0, 255));
    if (r < alloc_pct) begin
      c.action = ACT_ALLOC;
    end else if (r < rel_end) begin
      c.action = ACT_RELEASE;
      if ($urandom_range(0, 3) != 0 && pool_sb.pick_used(id)) c.number = id;
    end else if (r < chk_end) begin
      c.action = ACT_CHECK;
      if ($urandom_range(0, 1) != 0 && pool_sb.pick_used(id)) c.number = id;
    end else begin
      c.action = ActReserved;
    end
    return c;
  endfunction

  // Called at a rising edge; returns at the edge that takes the transaction.
  task automatic issue_command(npa_req_t c, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Stop issuing and let every outstanding response come back.
  task automatic drain_pool_cmds();
    start <= 1'b0;
    @(posedge clk);
    while (pool_sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_capacity(logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned phase_cap   [NumPhases];
    int unsigned phase_len   [NumPhases];
    int unsigned phase_alloc [NumPhases];
    bit          idle_on;

    phase_cap   = '{8, 1, 40, 256, 511, 0, 257, 0};
    phase_len   = '{150, 60, 200, 250, 250, 100, 150, 150};
    phase_alloc = '{55, 50, 60, 70, 65, 50, 35, 50};
    rst_n     = 1'b0;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // tiny pool: exhaustion, bad checks and releases, LIFO reuse
    write_capacity(9'd2);
    issue_command(make_cmd(ACT_ALLOC, 8'd255), pick_gap(1));
    issue_command(make_cmd(ACT_ALLOC, 8'd0), pick_gap(1));
    issue_command(make_cmd(ACT_ALLOC, 8'd170), pick_gap(1));
    issue_command(make_cmd(ACT_CHECK, 8'd0), pick_gap(1));
    issue_command(make_cmd(ACT_CHECK, 8'd2), pick_gap(1));
    issue_command(make_cmd(ACT_CHECK, 8'd255), pick_gap(1));
    issue_command(make_cmd(ACT_RELEASE, 8'd1), pick_gap(1));
    issue_command(make_cmd(ACT_RELEASE, 8'd1), pick_gap(1));
    issue_command(make_cmd(ACT_RELEASE, 8'd2), pick_gap(1));
    issue_command(make_cmd(ACT_RELEASE, 8'd255), pick_gap(1));
    issue_command(make_cmd(ActReserved, 8'd255), pick_gap(1));
    issue_command(make_cmd(ACT_CHECK, 8'd1), pick_gap(1));
    issue_command(make_cmd(ACT_ALLOC, 8'd85), pick_gap(1));
    issue_command(make_cmd(ACT_RELEASE, 8'd0), pick_gap(1));
    issue_command(make_cmd(ACT_RELEASE, 8'd1), pick_gap(1));
    issue_command(make_cmd(ACT_ALLOC, 8'd0), pick_gap(1));
    issue_command(make_cmd(ACT_ALLOC, 8'd255), pick_gap(1));
    drain_pool_cmds();

    // capacity above the pool size saturates
    write_capacity(9'd511);
    issue_command(make_cmd(ACT_CHECK, 8'd255), pick_gap(1));
    issue_command(make_cmd(ACT_ALLOC, 8'd0), pick_gap(1));
    issue_command(make_cmd(ActReserved, 8'd0), pick_gap(1));
    issue_command(make_cmd(ACT_RELEASE, 8'd2), pick_gap(1));
    drain_pool_cmds();

    // zero capacity: stacked ids are still handed out
    write_capacity(9'd0);
    issue_command(make_cmd(ACT_ALLOC, 8'd127), pick_gap(1));
    issue_command(make_cmd(ACT_CHECK, 8'd0), pick_gap(1));
    issue_command(make_cmd(ACT_RELEASE, 8'd2), pick_gap(1));
    drain_pool_cmds();

    phase_cap[NumPhases-1] = $urandom_range(0, 511);
    for (int p = 0; p < NumPhases; p++) begin
      write_capacity(9'(phase_cap[p]));
      idle_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < phase_len[p]; n++) begin
        issue_command(random_command(phase_alloc[p]), pick_gap(idle_on));
      end
      drain_pool_cmds();
    end

    $display("Covered %0d commands: %0d grants, %0d refused allocations, %0d releases,",
             pool_sb.commands, pool_sb.grants, pool_sb.refusals, pool_sb.releases);
    $display("across %0d capacity writes from 0 up to 511.", pool_sb.cap_writes);
    if (pool_sb.errors == 0 && pool_sb.pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[number_pool_allocator_unit.f]
rtl/npa_pkg.sv
rtl/npa_ram.sv
rtl/number_pool_allocator_unit.sv
dv/testbench.sv
